### sv/stuffed_frame_receiver_with_ack_top_macros.svh
// Assertion helpers for the frame receiver.
// Both expect clk and rst_n in the scope where they are used.
`ifndef STUFFED_FRAME_RECEIVER_WITH_ACK_TOP_MACROS_SVH
`define STUFFED_FRAME_RECEIVER_WITH_ACK_TOP_MACROS_SVH

// Condition holds in the same cycle as the trigger
`define SFR_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// Condition holds in the cycle after the trigger
`define SFR_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

### sv/sfr_pkg.sv
`timescale 1ns / 1ps

package sfr_pkg;

  // Line framing bytes
  localparam logic [7:0] LINE_FLAG   = 8'h7E;
  localparam logic [7:0] LINE_ESC    = 8'h7D;
  localparam logic [7:0] ESC_OF_ESC  = 8'h5D;
  localparam logic [7:0] ESC_OF_FLAG = 8'h5E;
  localparam logic [7:0] CHECK_INIT  = 8'h00;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SENDER_ADDR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECV_ADDR   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INFO_ZERO   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INFO_ONE    = 8'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_READY_ZERO  = 8'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_READY_ONE   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_ZERO = 8'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_REJECT_ONE  = 8'd7;

  // Configuration reset values
  localparam logic [7:0] RST_SENDER_ADDR = 8'd3;
  localparam logic [7:0] RST_RECV_ADDR   = 8'd1;
  localparam logic [7:0] RST_INFO_ZERO   = 8'd0;
  localparam logic [7:0] RST_INFO_ONE    = 8'd128;
  localparam logic [7:0] RST_READY_ZERO  = 8'd170;
  localparam logic [7:0] RST_READY_ONE   = 8'd171;
  localparam logic [7:0] RST_REJECT_ZERO = 8'd84;
  localparam logic [7:0] RST_REJECT_ONE  = 8'd85;

  // Reply status codes
  localparam logic [1:0] ST_NEW = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_ERR = 2'd2;

  // Reply frame beat positions
  localparam logic [2:0] BEAT_OPEN  = 3'd0;
  localparam logic [2:0] BEAT_ADDR  = 3'd1;
  localparam logic [2:0] BEAT_CTRL  = 3'd2;
  localparam logic [2:0] BEAT_CHECK = 3'd3;
  localparam logic [2:0] BEAT_CLOSE = 3'd4;

  // Result queue depth
  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  typedef struct packed {
    logic [7:0] sender_addr;
    logic [7:0] recv_addr;
    logic [7:0] info_zero;
    logic [7:0] info_one;
    logic [7:0] ready_zero;
    logic [7:0] ready_one;
    logic [7:0] reject_zero;
    logic [7:0] reject_one;
  } cfg_t;

  // One queued result: a payload byte, or a whole reply frame
  typedef struct packed {
    logic       is_reply;
    logic [7:0] data;    // payload byte, or receiver address of a reply
    logic [7:0] ctrl;
    logic [1:0] status;
  } desc_t;

  typedef struct packed {
    logic [1:0] count;
    logic [2:0] beat;
  } ser_status_t;

endpackage

### sv/sfr_cfg_regs.sv
`timescale 1ns / 1ps

module sfr_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_data,
  output sfr_pkg::cfg_t                  cfg
);

  sfr_pkg::cfg_t cfg_r;
  sfr_pkg::cfg_t cfg_nxt;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register decode; unknown indexes are ignored
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        sfr_pkg::CFG_SENDER_ADDR: cfg_nxt.sender_addr = cfg_data;
        sfr_pkg::CFG_RECV_ADDR:   cfg_nxt.recv_addr   = cfg_data;
        sfr_pkg::CFG_INFO_ZERO:   cfg_nxt.info_zero   = cfg_data;
        sfr_pkg::CFG_INFO_ONE:    cfg_nxt.info_one    = cfg_data;
        sfr_pkg::CFG_READY_ZERO:  cfg_nxt.ready_zero  = cfg_data;
        sfr_pkg::CFG_READY_ONE:   cfg_nxt.ready_one   = cfg_data;
        sfr_pkg::CFG_REJECT_ZERO: cfg_nxt.reject_zero = cfg_data;
        sfr_pkg::CFG_REJECT_ONE:  cfg_nxt.reject_one  = cfg_data;
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sender_addr <= sfr_pkg::RST_SENDER_ADDR;
      cfg_r.recv_addr   <= sfr_pkg::RST_RECV_ADDR;
      cfg_r.info_zero   <= sfr_pkg::RST_INFO_ZERO;
      cfg_r.info_one    <= sfr_pkg::RST_INFO_ONE;
      cfg_r.ready_zero  <= sfr_pkg::RST_READY_ZERO;
      cfg_r.ready_one   <= sfr_pkg::RST_READY_ONE;
      cfg_r.reject_zero <= sfr_pkg::RST_REJECT_ZERO;
      cfg_r.reject_one  <= sfr_pkg::RST_REJECT_ONE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### sv/sfr_core.sv
`timescale 1ns / 1ps

module sfr_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_accept,
  input  logic [7:0]            in_line_byte,
  input  sfr_pkg::cfg_t         cfg,
  output logic                  push,
  output sfr_pkg::desc_t        push_desc
);

  // Frame phases; unused codes behave as hunting
  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_CTRL = 3'd2;
  localparam logic [2:0] PH_HCHK = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;

  logic [2:0] phase_r, phase_nxt;
  logic       header_seq_r, header_seq_nxt;
  logic       expected_seq_r, expected_seq_nxt;
  logic       esc_r, esc_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_valid_r, held_valid_nxt;

  // Per-byte frame handling
  always_comb begin
    logic       have;
    logic [7:0] data;
    logic [7:0] ctrl;
    logic [7:0] hdr_ctrl;

    phase_nxt        = phase_r;
    header_seq_nxt   = header_seq_r;
    expected_seq_nxt = expected_seq_r;
    esc_nxt          = esc_r;
    xor_nxt          = xor_r;
    held_nxt         = held_r;
    held_valid_nxt   = held_valid_r;
    push             = 1'b0;
    push_desc        = '0;
    have             = 1'b0;
    data             = 8'h00;
    ctrl             = 8'h00;
    hdr_ctrl         = header_seq_r ? cfg.info_one : cfg.info_zero;

    if (in_accept) begin
      case (phase_r)
        PH_ADDR: begin
          if (in_line_byte == cfg.sender_addr) begin
            phase_nxt = PH_CTRL;
          end else begin
            phase_nxt = (in_line_byte == sfr_pkg::LINE_FLAG) ? PH_ADDR : PH_HUNT;
          end
        end
        PH_CTRL: begin
          // equal info controls resolve to sequence 0
          if (in_line_byte == cfg.info_zero) begin
            header_seq_nxt = 1'b0;
            phase_nxt      = PH_HCHK;
          end else if (in_line_byte == cfg.info_one) begin
            header_seq_nxt = 1'b1;
            phase_nxt      = PH_HCHK;
          end else begin
            phase_nxt = (in_line_byte == sfr_pkg::LINE_FLAG) ? PH_ADDR : PH_HUNT;
          end
        end
        PH_HCHK: begin
          if (in_line_byte == (cfg.sender_addr ^ hdr_ctrl)) begin
            phase_nxt      = PH_DATA;
            xor_nxt        = sfr_pkg::CHECK_INIT;
            esc_nxt        = 1'b0;
            held_valid_nxt = 1'b0;
          end else begin
            phase_nxt = (in_line_byte == sfr_pkg::LINE_FLAG) ? PH_ADDR : PH_HUNT;
          end
        end
        PH_DATA: begin
          if (in_line_byte == sfr_pkg::LINE_FLAG) begin
            // closing flag: queue the reply, held check byte is dropped
            push_desc.is_reply = 1'b1;
            push_desc.data     = cfg.recv_addr;
            if (xor_r == sfr_pkg::CHECK_INIT) begin
              if (header_seq_r == expected_seq_r) begin
                push_desc.status = sfr_pkg::ST_NEW;
                expected_seq_nxt = ~expected_seq_r;
              end else begin
                push_desc.status = sfr_pkg::ST_DUP;
              end
              ctrl = expected_seq_nxt ? cfg.ready_one : cfg.ready_zero;
            end else begin
              push_desc.status = sfr_pkg::ST_ERR;
              ctrl = expected_seq_r ? cfg.reject_one : cfg.reject_zero;
            end
            push_desc.ctrl = ctrl;
            push           = 1'b1;
            phase_nxt      = PH_HUNT;
            esc_nxt        = 1'b0;
            held_valid_nxt = 1'b0;
            xor_nxt        = sfr_pkg::CHECK_INIT;
          end else begin
            // destuffing; a bad escape pair is dropped
            if (esc_r) begin
              esc_nxt = 1'b0;
              if (in_line_byte == sfr_pkg::ESC_OF_ESC) begin
                data = sfr_pkg::LINE_ESC;
                have = 1'b1;
              end else if (in_line_byte == sfr_pkg::ESC_OF_FLAG) begin
                data = sfr_pkg::LINE_FLAG;
                have = 1'b1;
              end
            end else if (in_line_byte == sfr_pkg::LINE_ESC) begin
              esc_nxt = 1'b1;
            end else begin
              data = in_line_byte;
              have = 1'b1;
            end
            if (have) begin
              xor_nxt = xor_r ^ data;
              if (held_valid_r) begin
                push_desc.is_reply = 1'b0;
                push_desc.data     = held_r;
                push_desc.status   = sfr_pkg::ST_NEW;
                push               = 1'b1;
              end
              held_nxt       = data;
              held_valid_nxt = 1'b1;
            end
          end
        end
        default: begin
          phase_nxt = (in_line_byte == sfr_pkg::LINE_FLAG) ? PH_ADDR : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_HUNT;
      header_seq_r   <= 1'b0;
      expected_seq_r <= 1'b0;
      esc_r          <= 1'b0;
      xor_r          <= sfr_pkg::CHECK_INIT;
      held_valid_r   <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      header_seq_r   <= header_seq_nxt;
      expected_seq_r <= expected_seq_nxt;
      esc_r          <= esc_nxt;
      xor_r          <= xor_nxt;
      held_valid_r   <= held_valid_nxt;
    end
  end

  // held byte is only read while marked valid
  always_ff @(posedge clk) begin
    held_r <= held_nxt;
  end

endmodule

### sv/sfr_reply_ser.sv
`timescale 1ns / 1ps

module sfr_reply_ser (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sfr_pkg::desc_t        push_desc,
  output logic                  full,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_kind,
  output logic [7:0]            out_byte,
  output logic [1:0]            out_frame_status,
  output logic                  out_last_of_run,
  output sfr_pkg::ser_status_t  status
);

  sfr_pkg::desc_t q_r [2];
  logic           rd_ptr_r, rd_ptr_nxt;
  logic           wr_ptr_r, wr_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic [2:0]     beat_r, beat_nxt;

  sfr_pkg::desc_t head;
  logic           beat_done;
  logic           pop;

  assign head      = q_r[rd_ptr_r];
  assign full      = (count_r == sfr_pkg::QUEUE_DEPTH);
  assign out_valid = (count_r != 2'd0);
  assign beat_done = out_valid && !out_stall;
  assign pop       = beat_done && (!head.is_reply || beat_r == sfr_pkg::BEAT_CLOSE);

  assign status.count = count_r;
  assign status.beat  = beat_r;

  // Queue pointers and reply beat counter
  always_comb begin
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
    beat_nxt   = beat_r;
    if (beat_done) begin
      beat_nxt = pop ? sfr_pkg::BEAT_OPEN : beat_r + 3'd1;
    end
  end

  // Beat formatting from the head entry
  always_comb begin
    out_kind         = head.is_reply;
    out_frame_status = head.is_reply ? head.status : sfr_pkg::ST_NEW;
    out_last_of_run  = head.is_reply && (beat_r == sfr_pkg::BEAT_CLOSE);
    if (!head.is_reply) begin
      out_byte = head.data;
    end else begin
      case (beat_r)
        sfr_pkg::BEAT_OPEN:  out_byte = sfr_pkg::LINE_FLAG;
        sfr_pkg::BEAT_ADDR:  out_byte = head.data;
        sfr_pkg::BEAT_CTRL:  out_byte = head.ctrl;
        sfr_pkg::BEAT_CHECK: out_byte = head.data ^ head.ctrl;
        default:             out_byte = sfr_pkg::LINE_FLAG;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
      beat_r   <= sfr_pkg::BEAT_OPEN;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
      beat_r   <= beat_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

### sv/stuffed_frame_receiver_with_ack_top.sv
// Stop-and-wait frame receiver. Raw line bytes enter on the in_ channel, one
// per cycle while in_stall is low; each is handled in the cycle it is
// accepted. Destuffed payload bytes leave on the out_ channel one byte behind
// the line (the trailing check byte never appears), and each closing flag
// yields a five-byte reply frame (flag, address, control, header check, flag)
// with last_of_run on the final byte. Results pass through a two-entry queue
// that holds whole reply frames as one entry. While out_stall is low, a reply
// is serialised at one byte per cycle and payload sustains one byte per cycle;
// in_stall rises only when both queue entries are occupied.
// Configuration registers are written through cfg_ (always ready) and must
// only change while the receiver is idle.
`timescale 1ns / 1ps

`include "stuffed_frame_receiver_with_ack_top_macros.svh"

module stuffed_frame_receiver_with_ack_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_line_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_kind,
  output logic [7:0]                    out_byte,
  output logic [1:0]                    out_frame_status,
  output logic                          out_last_of_run,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  sfr_pkg::cfg_t        cfg;
  sfr_pkg::desc_t       push_desc;
  sfr_pkg::ser_status_t ser;
  logic                 push;
  logic                 full;
  logic                 in_accept;

  assign in_stall  = full;
  assign in_accept = in_valid && !full;

  sfr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sfr_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_accept    (in_accept),
    .in_line_byte (in_line_byte),
    .cfg          (cfg),
    .push         (push),
    .push_desc    (push_desc)
  );

  sfr_reply_ser u_ser (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .push_desc        (push_desc),
    .full             (full),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte         (out_byte),
    .out_frame_status (out_frame_status),
    .out_last_of_run  (out_last_of_run),
    .status           (ser)
  );

  // Checks on queue and reply sequencing
  `SFR_ASSERT_SAME(a_queue_bound, 1'b1, ser.count <= sfr_pkg::QUEUE_DEPTH, "queue overfilled")
  `SFR_ASSERT_SAME(a_beat_reply_only, out_valid && ser.beat != sfr_pkg::BEAT_OPEN, out_kind, "beat moved on payload")
  `SFR_ASSERT_SAME(a_last_is_flag, out_valid && out_last_of_run, out_kind && out_byte == sfr_pkg::LINE_FLAG, "bad reply end")
  `SFR_ASSERT_NEXT(a_beat_wraps, out_valid && !out_stall && out_last_of_run, ser.beat == sfr_pkg::BEAT_OPEN, "beat not reset")

endmodule
